@@ src/assert_macros.svh @@
// assertion macros shared by the shadow return stack monitor
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SRSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define SRSM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ src/srsm_pkg.sv @@
// types and constants of the shadow return stack monitor
package srsm_pkg;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_TUSER_W = 3;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned DEPTH_W     = 16;
  localparam int unsigned POPPED_W    = 7;
  localparam int unsigned THREAD_IN_W = 3;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 16'd10;

  typedef enum logic [1:0] {
    OP_CALL  = 2'd0,
    OP_RET   = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CALL_OK        = 3'd0,
    ST_CALL_OVF       = 3'd1,
    ST_RET_TOP        = 3'd2,
    ST_RET_BELOW      = 3'd3,
    ST_RET_NOT_FOUND  = 3'd4,
    ST_RET_AFTER_PUSH = 3'd5,
    ST_WR_CLEAN       = 3'd6,
    ST_WR_HIT         = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_DECIDE,
    S_SEARCH,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic clear;
    logic accept;
    logic load;
    logic decide;
    logic search;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic search_start;
    logic search_end;
    logic out_free;
  } sts_t;

endpackage

@@ src/shadow_return_stack_monitor.sv @@
// top level of the shadow return stack monitor
//
// channel  dir  tdata                                       tuser
// s_axis   in   [2:0] thread, [66:3] address, [67] after_push  [1:0] operation
// m_axis   out  [6:0] popped_entries, [22:7] call_depth        [2:0] status
//
// call, return after push, unused op or empty stack: an accepted item passes load, decide
// and finish, and the next item is taken back in idle; a scan reads the stack from the top
// down to the match, or over the fill count on a miss, at most STACK_DEPTH entries, one
// read per cycle; after reset a clearing pass sets the thread records; no input is taken
// a finished result waits in the output register while the next item is taken, and the
// next result holds until that register is free
module shadow_return_stack_monitor import srsm_pkg::*; #(
  parameter int unsigned THREADS     = 8,
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // thread, address, after_push, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // operation
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // popped_entries, call_depth, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // status
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o
);

  cmd_t cmd;
  sts_t sts;

  srsm_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  srsm_dp #(
    .THREADS     (THREADS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

@@ src/srsm_ram.sv @@
// generic single write port ram with registered read
module srsm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/srsm_ctrl.sv @@
// controller state machine of the shadow return stack monitor
`include "assert_macros.svh"

module srsm_ctrl import srsm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.search_start ? S_SEARCH : S_FINISH;
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (sts_i.search_end) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  `SRSM_ASSERT_NEXT(a_accept_load, cmd_o.accept, state_q == S_LOAD, "accept not followed by load")
  `SRSM_ASSERT_NEXT(a_search_exit, state_q == S_SEARCH && sts_i.search_end,
                    state_q == S_FINISH, "search end did not reach finish")

endmodule

@@ src/srsm_dp.sv @@
// datapath: item registers, thread records, shadow stack memory and result register
`include "assert_macros.svh"

module srsm_dp import srsm_pkg::*; #(
  parameter int unsigned THREADS     = 8,
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o
);

  localparam int unsigned TW  = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int unsigned SW  = $clog2(STACK_DEPTH);
  localparam int unsigned FW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned MD  = THREADS * STACK_DEPTH;
  localparam int unsigned MW  = $clog2(MD);
  localparam int unsigned RW  = SW + FW + DEPTH_W;

  function automatic logic [TW-1:0] thread_fold(input logic [THREAD_IN_W-1:0] th);
    logic [THREAD_IN_W-1:0] v;
    v = th;
    for (int i = 0; i < 8; i++) begin
      if (int'(v) >= THREADS) begin
        v = THREAD_IN_W'(int'(v) - THREADS);
      end
    end
    return TW'(v);
  endfunction

  function automatic logic [SW-1:0] slot_wrap(input logic [SW-1:0] base,
                                              input logic [SW-1:0] off);
    logic [SW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (SW+1)'(STACK_DEPTH)) begin
      sum = sum - (SW+1)'(STACK_DEPTH);
    end
    return sum[SW-1:0];
  endfunction

  // item registers
  op_e               op_q;
  logic [TW-1:0]     thr_q;
  logic [ADDR_W-1:0] addr_q;
  logic              ap_q;
  logic [MW-1:0]     tbase_q;

  // working thread record
  logic [SW-1:0]      base_q;
  logic [FW-1:0]      fill_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [FW-1:0]      k_q;
  logic [FW-1:0]      popped_q;
  status_e            status_q;

  logic [TW-1:0] clr_q;

  logic                   out_valid_q;
  status_e                out_status_q;
  logic [POPPED_W-1:0]    out_popped_q;
  logic [DEPTH_W-1:0]     out_depth_q;

  logic              trec_we;
  logic [TW-1:0]     trec_waddr;
  logic [RW-1:0]     trec_wdata;
  logic [RW-1:0]     trec_rdata;

  logic              full;
  logic [FW-1:0]     rd_k;
  logic [FW-1:0]     rd_off;
  logic [SW-1:0]     wr_slot;
  logic [SW-1:0]     rd_slot;
  logic              stk_we;
  logic [MW-1:0]     stk_waddr;
  logic [MW-1:0]     stk_raddr;
  logic [ADDR_W-1:0] stk_rdata;
  logic              match;
  logic              last;
  logic              search_op;

  // thread records, one per thread: {base, fill, depth}
  assign trec_we    = cmd_i.clear | cmd_i.finish;
  assign trec_waddr = cmd_i.clear ? clr_q : thr_q;
  assign trec_wdata = cmd_i.clear ? {{SW{1'b0}}, {FW{1'b0}}, DEPTH_RESET}
                                  : {base_q, fill_q, depth_q};

  srsm_ram #(
    .WIDTH (RW),
    .DEPTH (THREADS)
  ) u_trec_ram (
    .clk_i   (clk_i),
    .we_i    (trec_we),
    .waddr_i (trec_waddr),
    .wdata_i (trec_wdata),
    .raddr_i (thread_fold(s_axis_tdata_i[THREAD_IN_W-1:0])),
    .rdata_o (trec_rdata)
  );

  // shadow stacks, a ring of STACK_DEPTH slots per thread starting at base
  assign full      = fill_q == FW'(STACK_DEPTH);
  assign wr_slot   = slot_wrap(base_q, full ? '0 : SW'(fill_q));
  assign rd_k      = cmd_i.decide ? FW'(1) : FW'(k_q + FW'(1));
  assign rd_off    = fill_q - rd_k;
  assign rd_slot   = slot_wrap(base_q, SW'(rd_off));
  assign stk_we    = cmd_i.decide && (op_q == OP_CALL);
  assign stk_waddr = tbase_q + MW'(wr_slot);
  assign stk_raddr = tbase_q + MW'(rd_slot);

  srsm_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MD)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (addr_q),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign match     = stk_rdata == addr_q;
  assign last      = k_q == fill_q;
  assign search_op = (op_q == OP_WRITE) || (op_q == OP_RET && !ap_q);

  assign sts_o.clr_done     = clr_q == TW'(THREADS - 1);
  assign sts_o.search_start = search_op && (fill_q != '0);
  assign sts_o.search_end   = match || last;
  assign sts_o.out_free     = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_e'(s_axis_tuser_i[1:0]);
      thr_q  <= thread_fold(s_axis_tdata_i[THREAD_IN_W-1:0]);
      addr_q <= s_axis_tdata_i[THREAD_IN_W +: ADDR_W];
      ap_q   <= s_axis_tdata_i[THREAD_IN_W + ADDR_W];
    end
    if (cmd_i.load) begin
      tbase_q <= MW'(MW'(thr_q) * MW'(STACK_DEPTH));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      base_q   <= '0;
      fill_q   <= '0;
      depth_q  <= '0;
      k_q      <= '0;
      popped_q <= '0;
      status_q <= ST_WR_CLEAN;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + TW'(1);
      end
      if (cmd_i.load) begin
        depth_q <= trec_rdata[DEPTH_W-1:0];
        fill_q  <= trec_rdata[DEPTH_W +: FW];
        base_q  <= trec_rdata[DEPTH_W + FW +: SW];
      end
      if (cmd_i.decide) begin
        popped_q <= '0;
        k_q      <= FW'(1);
        unique case (op_q)
          OP_CALL: begin
            depth_q <= depth_q + DEPTH_W'(1);
            if (full) begin
              base_q   <= slot_wrap(base_q, SW'(1));
              popped_q <= FW'(1);
              status_q <= ST_CALL_OVF;
            end else begin
              fill_q   <= fill_q + FW'(1);
              status_q <= ST_CALL_OK;
            end
          end
          OP_RET: begin
            if (ap_q) begin
              status_q <= ST_RET_AFTER_PUSH;
              if (fill_q != '0) begin
                fill_q   <= fill_q - FW'(1);
                popped_q <= FW'(1);
              end
            end else begin
              status_q <= ST_RET_NOT_FOUND;
            end
          end
          OP_WRITE: status_q <= ST_WR_CLEAN;
          OP_NONE:  status_q <= ST_WR_CLEAN;
          default:  status_q <= ST_WR_CLEAN;
        endcase
      end
      if (cmd_i.search) begin
        if (match) begin
          if (op_q == OP_RET) begin
            status_q <= (k_q == FW'(1)) ? ST_RET_TOP : ST_RET_BELOW;
            popped_q <= k_q;
            fill_q   <= fill_q - k_q;
            depth_q  <= depth_q - DEPTH_W'(k_q);
          end else begin
            status_q <= ST_WR_HIT;
          end
        end else if (!last) begin
          k_q <= k_q + FW'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_status_q <= status_q;
      out_popped_q <= POPPED_W'(popped_q);
      out_depth_q  <= depth_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_depth_q, out_popped_q};
  assign m_axis_tuser_o  = out_status_q;

  `SRSM_ASSERT(a_search_range, cmd_i.search |-> (k_q != '0 && k_q <= fill_q),
               "search index outside the stack")
  `SRSM_ASSERT(a_fill_bound, fill_q <= FW'(STACK_DEPTH), "fill count above stack depth")
  `SRSM_ASSERT(a_result_free, cmd_i.finish |-> (!out_valid_q || m_axis_tready_i),
               "result register overwritten")

endmodule
